@@ rtl/modular_arithmetic_unit_macros.svh @@
// Assertion macros for the modular arithmetic unit
`ifndef MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define MAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define MAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/mau_pkg.sv @@
`timescale 1ns / 1ps
package mau_pkg;
	localparam logic [2:0] KIND_MUL = 3'd0;
	localparam logic [2:0] KIND_ADD = 3'd1;
	localparam logic [2:0] KIND_SUB = 3'd2;
	localparam logic [2:0] KIND_NEG = 3'd3;
	localparam logic [2:0] KIND_INV = 3'd4;
	localparam logic [2:0] KIND_DIV = 3'd5;
	localparam logic [2:0] KIND_POW = 3'd6;
	localparam logic [2:0] KIND_RED = 3'd7;
	localparam logic [30:0] MODULUS_RESET = 31'd998244353;
endpackage

@@ rtl/modular_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// Modular arithmetic unit: one item at a time, in_stall high until the result is registered.
// Operands reduced by restoring division, RESIDUE_BITS steps each (64 for signed
// reduce); a modular multiply holds the sequencer until the shared multiplier is done.
// Pow: per exponent bit, a multiply by the base when the bit is set, then a square;
// inverse and divide run shift-subtract extended Euclid.
// Async active-low reset sets modulus to 998244353 and empties the block.
module modular_arithmetic_unit #(
	parameter int RESIDUE_BITS  = 31,
	parameter int EXPONENT_BITS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [30:0]              cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               kind,
	input  logic [RESIDUE_BITS-1:0]  operand_a,
	input  logic [RESIDUE_BITS-1:0]  operand_b,
	input  logic [EXPONENT_BITS-1:0] exponent,
	input  logic signed [63:0]       signed_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [RESIDUE_BITS-1:0]  result,
	output logic                     no_inverse
);
	`include "modular_arithmetic_unit_macros.svh"
	localparam int W = RESIDUE_BITS;
	localparam int EW = EXPONENT_BITS;
	localparam int DW = 64;              // dividend width for reductions
	localparam int KW = $clog2(W);       // shift amount width for Euclid

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_REDA  = 4'd1;  // reduce a (or signed value)
	localparam logic [3:0] ST_REDB  = 4'd2;
	localparam logic [3:0] ST_DISP  = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;  // wait on multiplier
	localparam logic [3:0] ST_PBIT  = 4'd5;  // pow bit step
	localparam logic [3:0] ST_EUC   = 4'd6;  // Euclid step
	localparam logic [3:0] ST_EUCF  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;
	localparam logic [3:0] ST_PSQ   = 4'd9;  // pow: multiply/square pending

	logic [30:0] modulus_q;
	logic [3:0] st_q;
	logic [2:0] kind_q;
	logic [W-1:0] m;
	logic [DW-1:0] dvd_q;       // dividend being reduced, shifted out MSB first
	logic [W:0] rem_q;
	logic [6:0] rcnt_q;
	logic neg_q;
	logic [W-1:0] a_q, b_q, r_q;
	logic [EW-1:0] e_q;
	logic flag_q;
	logic mphase_q;             // 0 pow multiply, 1 pow square
	// extended Euclid: remainders s,t with coefficients c0,c1 of the operand
	logic [W-1:0] s_q, t_q;
	logic signed [W+2:0] c0_q, c1_q;
	logic [W-1:0] x1_q;         // inverse once Euclid finishes
	logic [W-1:0] result_q;
	logic no_inv_q;

	assign m = (modulus_q[W-1:0] == '0) ? W'(1) : modulus_q[W-1:0];

	// one shared multiplier
	logic mul_start, mul_busy, mul_done;
	logic [W-1:0] mul_a, mul_b, mul_p;
	mau_modmul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.m(m), .busy(mul_busy), .done(mul_done), .p(mul_p)
	);

	// restoring reduction step
	logic [W+1:0] rsh;
	logic [W:0] rnext;
	always_comb begin
		rsh = {rem_q, dvd_q[DW-1]};
		if (rsh >= {2'b0, m}) rnext = (W+1)'(rsh - {2'b0, m});
		else rnext = rsh[W:0];
	end

	function automatic logic [W-1:0] sub_mod(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] mm);
		logic [W:0] t;
		t = {1'b0, x} - {1'b0, y};
		if (t[W]) t = t + {1'b0, mm};
		return t[W-1:0];
	endfunction

	function automatic logic [KW-1:0] msb_pos(input logic [W-1:0] x);
		logic [KW-1:0] p;
		p = '0;
		for (int i = 0; i < W; i++)
			if (x[i]) p = KW'(i);
		return p;
	endfunction

	// largest t << k not above s (used only while s >= t > 0)
	logic [KW-1:0] sh_k;
	logic [W:0] t_sh;
	always_comb begin
		sh_k = msb_pos(s_q) - msb_pos(t_q);
		t_sh = {1'b0, t_q} << sh_k;
		if (t_sh > {1'b0, s_q}) begin
			sh_k = sh_k - 1'b1;
			t_sh = t_sh >> 1;
		end
	end

	// final coefficient folded into 0 .. m-1
	logic signed [W+2:0] c_fix;
	assign c_fix = c0_q[W+2] ? (c0_q + $signed({3'b0, m})) : c0_q;

	logic [W:0] addt;
	logic [W-1:0] add_r;
	always_comb begin
		addt = {1'b0, a_q} + {1'b0, b_q};
		if (addt >= {1'b0, m}) addt = addt - {1'b0, m};
		add_r = addt[W-1:0];
	end

	logic in_acc;
	assign in_stall = (st_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	// pow: r*a when the exponent bit is set, otherwise (and in PSQ) a*a
	assign mul_a = (st_q == ST_PBIT && e_q[0]) ? r_q : a_q;
	assign mul_b = (kind_q == mau_pkg::KIND_DIV) ? x1_q : ((kind_q == mau_pkg::KIND_MUL) ? b_q : a_q);

	always_comb begin
		mul_start = 1'b0;
		if (st_q == ST_DISP && kind_q == mau_pkg::KIND_MUL) mul_start = 1'b1;
		if (st_q == ST_PBIT && e_q != '0) mul_start = 1'b1;
		if (st_q == ST_PSQ && mul_done && !mphase_q) mul_start = 1'b1;
		if (st_q == ST_EUCF && kind_q == mau_pkg::KIND_DIV && !flag_q) mul_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mau_pkg::MODULUS_RESET;
			st_q <= ST_IDLE;
			out_valid <= 1'b0;
			result_q <= '0;
			no_inv_q <= 1'b0;
		end else begin
			if (cfg_we) modulus_q <= cfg_wdata;
			case (st_q)
				ST_IDLE: if (in_acc) st_q <= ST_REDA;
				ST_REDA: if (rcnt_q == 7'd1)
					st_q <= (kind_q == mau_pkg::KIND_RED) ? ST_OUT : ST_REDB;
				ST_REDB: if (rcnt_q == 7'd1) st_q <= ST_DISP;
				ST_DISP: begin
					case (kind_q)
						mau_pkg::KIND_MUL: st_q <= ST_MUL;
						mau_pkg::KIND_POW: st_q <= ST_PBIT;
						mau_pkg::KIND_INV, mau_pkg::KIND_DIV: st_q <= ST_EUC;
						default: st_q <= ST_OUT;
					endcase
				end
				ST_MUL: if (mul_done) st_q <= ST_OUT;
				ST_PBIT: st_q <= (e_q == '0) ? ST_OUT : ST_PSQ;
				ST_PSQ: if (mul_done && mphase_q) st_q <= ST_PBIT;
				ST_EUC: if (t_q == '0) st_q <= ST_EUCF;
				ST_EUCF: st_q <= (kind_q == mau_pkg::KIND_DIV && !flag_q) ? ST_MUL : ST_OUT;
				ST_OUT: begin
					// output register frees the core while a result waits
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						result_q <= r_q;
						no_inv_q <= flag_q && (kind_q == mau_pkg::KIND_INV ||
							kind_q == mau_pkg::KIND_DIV);
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (out_valid && !out_stall && st_q != ST_OUT) out_valid <= 1'b0;
		end
	end

	// datapath
	logic [63:0] mag;
	assign mag = signed_value[63] ? (64'd0 - signed_value) : signed_value;

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (in_acc) begin
				kind_q <= kind;
				a_q <= operand_a;
				b_q <= operand_b;
				e_q <= exponent;
				flag_q <= 1'b0;
				rem_q <= '0;
				rcnt_q <= (kind == mau_pkg::KIND_RED) ? 7'd64 : 7'(W);
				neg_q <= (kind == mau_pkg::KIND_RED) && signed_value[63];
				dvd_q <= (kind == mau_pkg::KIND_RED) ? mag : DW'(operand_a) << (DW - W);
			end
			ST_REDA: begin
				if (rcnt_q == 7'd1) begin
					if (kind_q == mau_pkg::KIND_RED)
						r_q <= (neg_q && rnext != '0) ? W'({1'b0, m} - rnext) : rnext[W-1:0];
					else a_q <= rnext[W-1:0];
					rem_q <= '0;
					rcnt_q <= 7'(W);
					dvd_q <= DW'(b_q) << (DW - W);
				end else begin
					rem_q <= rnext;
					dvd_q <= {dvd_q[DW-2:0], 1'b0};
					rcnt_q <= rcnt_q - 1'b1;
				end
			end
			ST_REDB: begin
				rem_q <= rnext;
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
				rcnt_q <= rcnt_q - 1'b1;
				if (rcnt_q == 7'd1) b_q <= rnext[W-1:0];
			end
			ST_DISP: begin
				mphase_q <= 1'b0;
				case (kind_q)
					mau_pkg::KIND_ADD: r_q <= add_r;
					mau_pkg::KIND_SUB: r_q <= sub_mod(a_q, b_q, m);
					mau_pkg::KIND_NEG: r_q <= sub_mod('0, a_q, m);
					mau_pkg::KIND_DIV: begin
						s_q <= m; t_q <= b_q; c0_q <= '0; c1_q <= (W+3)'(1);
					end
					mau_pkg::KIND_INV: begin
						s_q <= m; t_q <= a_q; c0_q <= '0; c1_q <= (W+3)'(1);
					end
					default: r_q <= (m == W'(1)) ? '0 : W'(1);
				endcase
			end
			ST_MUL: if (mul_done) r_q <= mul_p;
			ST_PBIT: mphase_q <= ~e_q[0];
			ST_PSQ: begin
				if (mul_done) begin
					if (!mphase_q) begin
						r_q <= mul_p;
						mphase_q <= 1'b1;
					end else begin
						a_q <= mul_p;
						e_q <= e_q >> 1;
					end
				end
			end
			ST_EUC: begin
				// gcd lands in s; zero operand leaves s = m
				if (t_q == '0) begin
					flag_q <= (s_q != W'(1));
					x1_q <= c_fix[W-1:0];
				end else if (s_q >= t_q) begin
					s_q <= s_q - t_sh[W-1:0];
					c0_q <= c0_q - (c1_q <<< sh_k);
				end else begin
					s_q <= t_q;
					t_q <= s_q;
					c0_q <= c1_q;
					c1_q <= c0_q;
				end
			end
			ST_EUCF: r_q <= flag_q ? '0 : x1_q;
			default: ;
		endcase
	end

	assign result = result_q;
	assign no_inverse = no_inv_q;

	`MAU_ASSERT_IMP(a_stall_busy, clk, arst_n, st_q != ST_IDLE, in_stall)
	`MAU_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_acc, st_q == ST_REDA)
	`MAU_ASSERT_IMP(a_result_in_range, clk, arst_n, out_valid, result < m || m == W'(1))
	`MAU_ASSERT_IMP(a_mul_idle_on_start, clk, arst_n, mul_start, !mul_busy)
endmodule

@@ rtl/mau_modmul.sv @@
`timescale 1ns / 1ps
// Shift-add modular multiplier: one bit of b per cycle, MSB first.
// Inputs must be reduced (a, b < m).
module mau_modmul #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] p
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] acc_q, a_q, b_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [W+1:0] dbl, sum;
	logic [W:0] r1;

	always_comb begin
		dbl = {1'b0, acc_q, 1'b0};
		if (dbl >= {2'b0, m}) dbl = dbl - {2'b0, m};
		sum = dbl + (b_q[W-1] ? {2'b0, a_q} : '0);
		if (sum >= {2'b0, m}) sum = sum - {2'b0, m};
		r1 = sum[W:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			acc_q <= r1[W-1:0];
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign p = acc_q;
endmodule
